FILE: sv/beam_survivor_pruner_assert.svh
// ----------------------------------------------------------------------------
// beam survivor pruner assertion macros
// concurrent checks on the clk_i domain, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BEAM_SURVIVOR_PRUNER_ASSERT_SVH
`define BEAM_SURVIVOR_PRUNER_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds at every clock edge
`define BSP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("beam survivor pruner check failed");
// pre at one edge implies post at the next
`define BSP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("beam survivor pruner check failed");
`else
`define BSP_ASSERT(lbl, expr)
`define BSP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: sv/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// shared constants and types of the beam survivor pruner
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int MAX_SURVIVORS  = 25;
  localparam int NODES_PER_PATH = 30;
  localparam int ELEMENT_STATES = 6;
  localparam int CAND_DEPTH     = MAX_SURVIVORS * NODES_PER_PATH;

  localparam int PROB_W = 24;
  localparam int MASS_W = 30;
  localparam int IDX_W  = $clog2(CAND_DEPTH);
  localparam int CCNT_W = $clog2(CAND_DEPTH + 1);
  localparam int SLOT_W = $clog2(MAX_SURVIVORS);
  localparam int SCNT_W = $clog2(MAX_SURVIVORS + 1);
  localparam int POS_W  = $clog2(NODES_PER_PATH);
  localparam int ES_W   = (ELEMENT_STATES > 1) ? $clog2(ELEMENT_STATES) : 1;
  localparam int KEY_W  = 32;

  // configuration register map
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_TARGET_MASS = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MIN_PROB    = 3'd4;
  localparam logic [PROB_W-1:0] TARGET_RESET    = 24'd15099494;
  localparam logic [PROB_W-1:0] MIN_RESET       = 24'd17;

  // one stored candidate
  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [9:0]        letter;
    logic [15:0]       duration;
    logic [5:0]        rate;
    logic [31:0]       estimate;
    logic [31:0]       variance;
  } cand_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROB_W-1:0] num;
    logic [MASS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: sv/bsp_divider.sv
// ----------------------------------------------------------------------------
// bsp_divider
// restoring divider, one quotient bit per cycle: floor(num * 2^24 / den),
// saturated to 24 bits, zero when den is zero
// ----------------------------------------------------------------------------
module bsp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsp_pkg::div_req_t req_i,
  output bsp_pkg::div_rsp_t rsp_o
);
  import bsp_pkg::*;

  localparam int QW = PROB_W + 1;
  localparam int CW = $clog2(QW + 1);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [MASS_W-1:0] rem_q, den_q;
  logic [QW-1:0]     sh_q, quo_q;
  logic              zero_q, done_q;
  logic [MASS_W:0]   trial;
  logic              ge;

  // one trial subtraction per step
  assign trial = {rem_q, sh_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= MASS_W'(req_i.num[PROB_W-1:1]);
      sh_q   <= {req_i.num[0], {PROB_W{1'b0}}};
      den_q  <= req_i.den;
      zero_q <= (req_i.den == '0);
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? MASS_W'(trial - {1'b0, den_q}) : MASS_W'(trial);
      sh_q  <= {sh_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = zero_q ? '0 :
                      (quo_q[QW-1] ? {PROB_W{1'b1}} : quo_q[PROB_W-1:0]);

endmodule

FILE: sv/beam_survivor_pruner.sv
// ----------------------------------------------------------------------------
// beam_survivor_pruner
// keeps the best candidate per element state, tops up to a target mass,
// merges duplicate survivors and emits renormalized survivors
// ----------------------------------------------------------------------------
// usage:
//   candidates enter on the input channel (valid/stall), one per cycle, while
//   the block is loading. the item with last_in set starts a run; in_stall_o
//   stays high until the last survivor of the run sits in the output register.
//   each survivor is one transfer on the output channel, in selection order,
//   with is_best on the first highest and last_out on the final one.
//   a run over T loaded candidates (T a multiple of 30) does one scan of the
//   candidate memory per element state and one per extra survivor, a merge
//   of each new survivor against the earlier ones, then a bit-serial
//   division per kept survivor and one transfer per kept survivor.
//   a trailing partial path is ignored; with no full path nothing is sent.
//   reset clears control state and the registers to their defaults; the
//   candidate memory needs no clearing pass. a stalled receiver holds the
//   output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module beam_survivor_pruner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // candidate input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [23:0]                prob_i,
  input  logic [9:0]                 letter_state_i,
  input  logic [15:0]                duration_i,
  input  logic [5:0]                 rate_i,
  input  logic signed [31:0]         estimate_i,
  input  logic [31:0]                variance_i,
  input  logic                       last_in_i,
  // survivor output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [23:0]                out_prob_o,
  output logic [4:0]                 parent_path_o,
  output logic [bsp_pkg::IDX_W-1:0]  node_index_o,
  output logic [9:0]                 out_letter_state_o,
  output logic [15:0]                out_duration_o,
  output logic [5:0]                 out_rate_o,
  output logic signed [31:0]         out_estimate_o,
  output logic [31:0]                out_variance_o,
  output logic                       is_best_o,
  output logic                       last_out_o
);
  import bsp_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN, S_PICK, S_KEYRD, S_KEYGET, S_MERGE, S_MDONE, S_NEXT,
    S_DIVST, S_DIVK, S_DIVW, S_EMST, S_EMK, S_EMRD, S_EMOUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [PROB_W-1:0] target_q, min_q;

  // load counters
  logic [CCNT_W-1:0] cnt_q, tot_q, tot_new;
  logic [POS_W-1:0]  pos_q;

  // scan state
  logic              phase1_q;
  logic [ES_W-1:0]   e_q;
  logic [CCNT_W-1:0] c_q;
  logic [POS_W-1:0]  cpos_q;
  logic [ES_W-1:0]   ces_q, res_q;
  logic [4:0]        cpath_q, rpath_q, bpath_q;
  logic              rv_q;
  logic [IDX_W-1:0]  ridx_q, bc_q;
  logic              found_q;
  logic [PROB_W-1:0] bp_q;

  // survivor bookkeeping
  logic [SCNT_W-1:0] n_q, j_q, k_q;
  logic [MASS_W-1:0] mass_q, kmass_q;
  logic [MAX_SURVIVORS-1:0] keep_q;
  logic [KEY_W-1:0]  key_q, krd_q;
  logic              kv_q, dup_q;
  logic [SLOT_W-1:0] lastk_q, bestk_q;
  logic [PROB_W-1:0] bestv_q;
  logic              bfound_q;

  logic [IDX_W-1:0]  chosen_idx [MAX_SURVIVORS];
  logic [PROB_W-1:0] chosen_prob [MAX_SURVIVORS];
  logic [4:0]        chosen_path [MAX_SURVIVORS];
  logic [PROB_W-1:0] qv [MAX_SURVIVORS];
  logic [KEY_W-1:0]  key_mem [MAX_SURVIVORS];

  // candidate memory and chosen marks
  cand_t             cand_mem [CAND_DEPTH];
  logic              ch_mem [CAND_DEPTH];
  cand_t             rd_q;
  logic              ch_rd_q;
  logic [IDX_W-1:0]  raddr;

  // output register
  logic              out_vld_q;

  // strobes
  logic              ld_acc, ld_store, ld_wrap, issue, kissue, eligible, better;
  logic              pick_add, div_done, out_free;
  logic [SLOT_W-1:0] n_s, k_s;
  logic [SCNT_W-1:0] n_inc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign n_s   = n_q[SLOT_W-1:0];
  assign k_s   = k_q[SLOT_W-1:0];
  assign n_inc = n_q + 1'b1;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      REG_TARGET_MASS: prdata = {8'd0, target_q};
      REG_MIN_PROB:    prdata = {8'd0, min_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
      min_q    <= MIN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_TARGET_MASS) target_q <= pwdata[PROB_W-1:0];
      if (paddr == REG_MIN_PROB)    min_q    <= pwdata[PROB_W-1:0];
    end
  end

  // handshake and load decode
  assign in_stall_o = (state_q != S_LOAD);
  assign ld_acc     = in_valid_i && !in_stall_o;
  assign ld_store   = ld_acc && (cnt_q < CCNT_W'(CAND_DEPTH));
  assign ld_wrap    = ld_store && (pos_q == POS_W'(NODES_PER_PATH - 1));
  assign tot_new    = ld_wrap ? CCNT_W'(tot_q + CCNT_W'(NODES_PER_PATH)) : tot_q;

  // scan decode
  assign issue    = (state_q == S_SCAN) && (c_q < tot_q);
  assign eligible = phase1_q ? (res_q == e_q) : !ch_rd_q;
  assign better   = phase1_q ? (rd_q.prob >= bp_q) : (!found_q || rd_q.prob > bp_q);
  assign pick_add = (state_q == S_PICK) &&
                    (phase1_q ? (found_q && bp_q >= min_q && n_q < SCNT_W'(MAX_SURVIVORS))
                              : found_q);
  assign kissue   = (state_q == S_MERGE) && (j_q < n_q);
  assign div_done = (state_q == S_DIVW) && div_rsp.done;
  assign out_free = !out_vld_q || !out_stall_i;

  // read address select
  always_comb begin
    unique case (state_q)
      S_KEYRD:        raddr = bc_q;
      S_EMRD, S_EMOUT: raddr = chosen_idx[k_s];
      default:        raddr = c_q[IDX_W-1:0];
    endcase
  end

  // candidate memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (ld_store) begin
      cand_mem[cnt_q[IDX_W-1:0]] <= '{prob: prob_i, letter: letter_state_i,
                                      duration: duration_i, rate: rate_i,
                                      estimate: estimate_i, variance: variance_i};
    end
    if (ld_store) begin
      ch_mem[cnt_q[IDX_W-1:0]] <= 1'b0;
    end else if (pick_add) begin
      ch_mem[bc_q] <= 1'b1;
    end
    rd_q    <= cand_mem[raddr];
    ch_rd_q <= ch_mem[raddr];
  end

  // survivor tables
  always_ff @(posedge clk_i) begin
    if (pick_add) begin
      chosen_idx[n_s]  <= bc_q;
      chosen_prob[n_s] <= bp_q;
      chosen_path[n_s] <= bpath_q;
    end
    if (state_q == S_MDONE) key_mem[n_s] <= key_q;
    krd_q <= key_mem[j_q[SLOT_W-1:0]];
    if (div_done) qv[k_s] <= div_rsp.quo;
  end

  // shared divider
  assign div_req.start = (state_q == S_DIVK) && (k_q != n_q) && keep_q[k_s];
  assign div_req.num   = chosen_prob[k_s];
  assign div_req.den   = kmass_q;

  bsp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      tot_q     <= '0;
      pos_q     <= '0;
      phase1_q  <= 1'b0;
      e_q       <= '0;
      c_q       <= '0;
      cpos_q    <= '0;
      ces_q     <= '0;
      cpath_q   <= '0;
      rv_q      <= 1'b0;
      res_q     <= '0;
      rpath_q   <= '0;
      ridx_q    <= '0;
      found_q   <= 1'b0;
      bp_q      <= '0;
      bc_q      <= '0;
      bpath_q   <= '0;
      n_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      mass_q    <= '0;
      kmass_q   <= '0;
      keep_q    <= '0;
      key_q     <= '0;
      kv_q      <= 1'b0;
      dup_q     <= 1'b0;
      lastk_q   <= '0;
      bestk_q   <= '0;
      bestv_q   <= '0;
      bfound_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      // output register drains on transfer
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;

      // scan read pipeline
      rv_q    <= issue;
      ridx_q  <= c_q[IDX_W-1:0];
      res_q   <= ces_q;
      rpath_q <= cpath_q;
      kv_q    <= kissue;

      unique case (state_q)
        // load candidates
        S_LOAD: begin
          if (ld_acc) begin
            if (ld_store) begin
              cnt_q <= cnt_q + 1'b1;
              pos_q <= ld_wrap ? '0 : POS_W'(pos_q + 1'b1);
            end
            tot_q <= tot_new;
            if (last_in_i) begin
              cnt_q <= '0;
              pos_q <= '0;
              if (tot_new == '0) begin
                tot_q <= '0;
              end else begin
                n_q      <= '0;
                mass_q   <= '0;
                kmass_q  <= '0;
                phase1_q <= 1'b1;
                e_q      <= '0;
                c_q      <= '0;
                cpos_q   <= '0;
                ces_q    <= '0;
                cpath_q  <= '0;
                found_q  <= 1'b0;
                bp_q     <= '0;
                bc_q     <= '0;
                state_q  <= S_SCAN;
              end
            end
          end
        end

        // one pass over the stored candidates of full paths
        S_SCAN: begin
          if (issue) begin
            c_q <= c_q + 1'b1;
            if (cpos_q == POS_W'(NODES_PER_PATH - 1)) begin
              cpos_q  <= '0;
              ces_q   <= '0;
              cpath_q <= cpath_q + 1'b1;
            end else begin
              cpos_q <= cpos_q + 1'b1;
              ces_q  <= (ces_q == ES_W'(ELEMENT_STATES - 1)) ? '0 : ES_W'(ces_q + 1'b1);
            end
          end
          if (rv_q && eligible && better) begin
            found_q <= 1'b1;
            bp_q    <= rd_q.prob;
            bc_q    <= ridx_q;
            bpath_q <= rpath_q;
          end
          if (!issue && !rv_q) state_q <= S_PICK;
        end

        // decide on the scan winner
        S_PICK: begin
          if (pick_add) begin
            mass_q  <= mass_q + MASS_W'(bp_q);
            state_q <= S_KEYRD;
          end else if (phase1_q) begin
            state_q <= S_NEXT;
          end else begin
            state_q <= S_DIVST;
          end
        end

        S_KEYRD: state_q <= S_KEYGET;

        S_KEYGET: begin
          key_q   <= {rd_q.rate, rd_q.duration, rd_q.letter};
          j_q     <= '0;
          dup_q   <= 1'b0;
          state_q <= S_MERGE;
        end

        // compare with earlier survivors
        S_MERGE: begin
          if (kissue) j_q <= j_q + 1'b1;
          if (kv_q && krd_q == key_q) dup_q <= 1'b1;
          if (!kissue && !kv_q) state_q <= S_MDONE;
        end

        S_MDONE: begin
          keep_q[n_s] <= !dup_q;
          if (!dup_q) begin
            kmass_q <= kmass_q + MASS_W'(bp_q);
            lastk_q <= n_s;
          end
          n_q     <= n_inc;
          state_q <= S_NEXT;
        end

        // choose the next scan or finish selection
        S_NEXT: begin
          found_q <= 1'b0;
          bp_q    <= '0;
          bc_q    <= '0;
          c_q     <= '0;
          cpos_q  <= '0;
          ces_q   <= '0;
          cpath_q <= '0;
          if (phase1_q && e_q != ES_W'(ELEMENT_STATES - 1)) begin
            e_q     <= e_q + 1'b1;
            state_q <= S_SCAN;
          end else if (phase1_q) begin
            phase1_q <= 1'b0;
            state_q  <= (n_q < SCNT_W'(MAX_SURVIVORS)) ? S_SCAN : S_DIVST;
          end else if (n_q == SCNT_W'(MAX_SURVIVORS) || mass_q >= MASS_W'(target_q)) begin
            state_q <= S_DIVST;
          end else begin
            state_q <= S_SCAN;
          end
        end

        // normalize every kept survivor
        S_DIVST: begin
          k_q      <= '0;
          bfound_q <= 1'b0;
          state_q  <= S_DIVK;
        end

        S_DIVK: begin
          if (k_q == n_q) begin
            state_q <= S_EMST;
          end else if (!keep_q[k_s]) begin
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= S_DIVW;
          end
        end

        S_DIVW: begin
          if (div_rsp.done) begin
            if (!bfound_q || div_rsp.quo > bestv_q) begin
              bestv_q <= div_rsp.quo;
              bestk_q <= k_s;
            end
            bfound_q <= 1'b1;
            k_q      <= k_q + 1'b1;
            state_q  <= S_DIVK;
          end
        end

        // emit survivors in selection order
        S_EMST: begin
          k_q     <= '0;
          state_q <= S_EMK;
        end

        S_EMK: begin
          if (k_q == n_q) begin
            tot_q   <= '0;
            state_q <= S_LOAD;
          end else if (!keep_q[k_s]) begin
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= S_EMRD;
          end
        end

        S_EMRD: state_q <= S_EMOUT;

        S_EMOUT: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            k_q       <= k_q + 1'b1;
            state_q   <= S_EMK;
          end
        end

        default: state_q <= S_LOAD;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMOUT && out_free) begin
      out_prob_o         <= qv[k_s];
      parent_path_o      <= chosen_path[k_s];
      node_index_o       <= chosen_idx[k_s];
      out_letter_state_o <= rd_q.letter;
      out_duration_o     <= rd_q.duration;
      out_rate_o         <= rd_q.rate;
      out_estimate_o     <= rd_q.estimate;
      out_variance_o     <= rd_q.variance;
      is_best_o          <= (k_s == bestk_q);
      last_out_o         <= (k_s == lastk_q);
    end
  end

  assign out_valid_o = out_vld_q;

  // checks
  `include "beam_survivor_pruner_assert.svh"

  `BSP_ASSERT(a_slot_limit, n_q <= SCNT_W'(MAX_SURVIVORS))
  `BSP_ASSERT(a_kept_mass, kmass_q <= mass_q)
  `BSP_ASSERT(a_first_kept, (n_q == '0) || keep_q[0])
  `BSP_ASSERT(a_emit_kept, (state_q != S_EMOUT) || keep_q[k_s])
  `BSP_ASSERT_NEXT(a_div_result, div_req.start, state_q == S_DIVW && !div_rsp.done)

endmodule
